/* hdl/cwa_pkg.sv */
// Shared widths, width helpers and queue status type for the window average block.
`timescale 1ns / 1ps
`default_nettype none

package cwa_pkg;

   // Sample field widths
   localparam int TEMP_W      = 15;
   localparam int HUMID_W     = 14;
   localparam int CO2_W       = 14;
   localparam int SAMPLE_W    = TEMP_W + HUMID_W + CO2_W;
   localparam int COUNT_OUT_W = 5;

   // Default window length
   localparam int DEPTH_DEFAULT = 16;

   // Job queue between the update front and the divide back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Bits to hold a count of 0..depth
   function automatic int count_width(input int depth);
      return $clog2(depth + 1);
   endfunction

   // Signed running total of depth temperatures
   function automatic int temp_total_width(input int depth);
      return $clog2(depth * (1 << (TEMP_W - 1)) + 1) + 1;
   endfunction

   // Unsigned running total of depth humidity readings
   function automatic int humid_total_width(input int depth);
      return $clog2(depth * ((1 << HUMID_W) - 1) + 1);
   endfunction

   // Unsigned running total of depth CO2 readings
   function automatic int co2_total_width(input int depth);
      return $clog2(depth * ((1 << CO2_W) - 1) + 1);
   endfunction

   // One queued job: three totals and the entry count
   function automatic int job_width(input int depth);
      return temp_total_width(depth) + humid_total_width(depth)
           + co2_total_width(depth) + count_width(depth);
   endfunction

endpackage

`default_nettype wire

/* hdl/cwa_queue.sv */
// Small job queue that decouples the ring update front from the divide back.
`timescale 1ns / 1ps
`default_nettype none

module cwa_queue #(
   parameter int WIDTH = cwa_pkg::job_width(cwa_pkg::DEPTH_DEFAULT)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [WIDTH-1:0]         push_data,
   input  wire logic                     pop,
   output cwa_pkg::queue_status_type     status,
   output logic      [WIDTH-1:0]         pop_data
);

   logic [WIDTH-1:0]                  entry_ff [cwa_pkg::QUEUE_DEPTH];
   logic [cwa_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [cwa_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [cwa_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [cwa_pkg::QUEUE_CNT_W-1:0]   count_in;

   assign status.full  = (count_ff == cwa_pkg::QUEUE_CNT_W'(cwa_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Occupancy after this cycle's transfers
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A pop only ever takes a stored job
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("job queue popped while empty");

endmodule

`default_nettype wire

/* hdl/cwa_front.sv */
// Front end: accepts readings, updates the sample ring and running totals, queues a job.
`timescale 1ns / 1ps
`default_nettype none

module cwa_front #(
   parameter int DEPTH = cwa_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [cwa_pkg::TEMP_W-1:0]     req_temp_centi,
   input  wire logic        [cwa_pkg::HUMID_W-1:0]    req_humid_centi,
   input  wire logic        [cwa_pkg::CO2_W-1:0]      req_co2_ppm,
   input  cwa_pkg::queue_status_type                  queue_status,
   output logic                                       push,
   output logic [cwa_pkg::job_width(DEPTH)-1:0]       push_data
);

   localparam int CNT_W    = cwa_pkg::count_width(DEPTH);
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TT_W     = cwa_pkg::temp_total_width(DEPTH);
   localparam int HT_W     = cwa_pkg::humid_total_width(DEPTH);
   localparam int CT_W     = cwa_pkg::co2_total_width(DEPTH);
   localparam int SAMPLE_W = cwa_pkg::SAMPLE_W;
   localparam int TEMP_W   = cwa_pkg::TEMP_W;
   localparam int HUMID_W  = cwa_pkg::HUMID_W;
   localparam int CO2_W    = cwa_pkg::CO2_W;

   typedef enum logic {
      F_IDLE,
      F_UPDATE
   } front_state_type;

   front_state_type          state_ff;
   logic [PTR_W-1:0]         pos_ff;
   logic [PTR_W-1:0]         pos_in;
   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;
   logic signed [TT_W-1:0]   temp_total_ff;
   logic signed [TT_W-1:0]   temp_total_in;
   logic [HT_W-1:0]          humid_total_ff;
   logic [HT_W-1:0]          humid_total_in;
   logic [CT_W-1:0]          co2_total_ff;
   logic [CT_W-1:0]          co2_total_in;
   logic [SAMPLE_W-1:0]      new_sample_ff;
   logic [SAMPLE_W-1:0]      old_sample_ff;
   logic [SAMPLE_W-1:0]      store_mem [DEPTH];

   logic                     accept;
   logic                     full;
   logic [TEMP_W-1:0]        new_temp;
   logic [TEMP_W-1:0]        old_temp;
   logic [HUMID_W-1:0]       new_humid;
   logic [HUMID_W-1:0]       old_humid;
   logic [CO2_W-1:0]         new_co2;
   logic [CO2_W-1:0]         old_co2;
   logic signed [TT_W-1:0]   temp_add;
   logic signed [TT_W-1:0]   temp_sub;
   logic [HT_W-1:0]          humid_sub;
   logic [CT_W-1:0]          co2_sub;

   // One reading at a time; the queue must have room for its job
   assign req_stall = (state_ff != F_IDLE) || queue_status.full;
   assign accept    = req_valid && !req_stall;

   // Unpack current and displaced samples
   assign new_temp  = new_sample_ff[SAMPLE_W-1 -: TEMP_W];
   assign new_humid = new_sample_ff[CO2_W +: HUMID_W];
   assign new_co2   = new_sample_ff[CO2_W-1:0];
   assign old_temp  = old_sample_ff[SAMPLE_W-1 -: TEMP_W];
   assign old_humid = old_sample_ff[CO2_W +: HUMID_W];
   assign old_co2   = old_sample_ff[CO2_W-1:0];

   // Once the ring is full the overwritten entry leaves the totals
   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign temp_add = {{(TT_W-TEMP_W){new_temp[TEMP_W-1]}}, new_temp};
   assign temp_sub = full ? {{(TT_W-TEMP_W){old_temp[TEMP_W-1]}}, old_temp} : '0;
   assign humid_sub = full ? {{(HT_W-HUMID_W){1'b0}}, old_humid} : '0;
   assign co2_sub   = full ? {{(CT_W-CO2_W){1'b0}}, old_co2} : '0;

   assign temp_total_in  = temp_total_ff + temp_add - temp_sub;
   assign humid_total_in = humid_total_ff + {{(HT_W-HUMID_W){1'b0}}, new_humid} - humid_sub;
   assign co2_total_in   = co2_total_ff + {{(CT_W-CO2_W){1'b0}}, new_co2} - co2_sub;
   assign fill_in        = full ? fill_ff : fill_ff + 1'b1;
   assign pos_in         = (pos_ff == PTR_W'(DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   // Job goes to the queue in the update cycle
   assign push      = (state_ff == F_UPDATE);
   assign push_data = {temp_total_in, humid_total_in, co2_total_in, fill_in};

   // Sample ring: write the new reading, fetch the one it replaces
   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[pos_ff] <= {req_temp_centi, req_humid_centi, req_co2_ppm};
         old_sample_ff     <= store_mem[pos_ff];
      end
   end

   // Control and running totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         pos_ff         <= '0;
         fill_ff        <= '0;
         temp_total_ff  <= '0;
         humid_total_ff <= '0;
         co2_total_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  new_sample_ff <= {req_temp_centi, req_humid_centi, req_co2_ppm};
                  pos_ff        <= pos_in;
                  state_ff      <= F_UPDATE;
               end
            end
            F_UPDATE: begin
               temp_total_ff  <= temp_total_in;
               humid_total_ff <= humid_total_in;
               co2_total_ff   <= co2_total_in;
               fill_ff        <= fill_in;
               state_ff       <= F_IDLE;
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   // The room checked at transfer time must still be there at push
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == F_UPDATE) |-> !queue_status.full)
      else $error("job pushed into a full queue");

   // Fill count never passes the window length
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond window length");

endmodule

`default_nettype wire

/* hdl/cwa_back.sv */
// Back end: three-lane restoring divider sharing one sequencer, plus result register.
`timescale 1ns / 1ps
`default_nettype none

module cwa_back #(
   parameter int DEPTH = cwa_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  cwa_pkg::queue_status_type                    queue_status,
   input  wire logic [cwa_pkg::job_width(DEPTH)-1:0]    pop_data,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [cwa_pkg::TEMP_W-1:0]            rsp_avg_temp_centi,
   output logic        [cwa_pkg::HUMID_W-1:0]           rsp_avg_humid_centi,
   output logic        [cwa_pkg::CO2_W-1:0]             rsp_avg_co2_ppm,
   output logic        [cwa_pkg::COUNT_OUT_W-1:0]       rsp_valid_entries
);

   localparam int CNT_W   = cwa_pkg::count_width(DEPTH);
   localparam int TT_W    = cwa_pkg::temp_total_width(DEPTH);
   localparam int HT_W    = cwa_pkg::humid_total_width(DEPTH);
   localparam int CT_W    = cwa_pkg::co2_total_width(DEPTH);
   localparam int DIV_W   = TT_W;
   localparam int STEP_W  = $clog2(DIV_W);
   localparam int LANES   = 3;
   localparam int OUT_W   = cwa_pkg::COUNT_OUT_W;
   localparam int LANE_T  = 0;
   localparam int LANE_H  = 1;
   localparam int LANE_C  = 2;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_DONE
   } back_state_type;

   back_state_type          state_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CNT_W-1:0]        divisor_ff;
   logic                    neg_ff;
   logic [DIV_W-1:0]        quo_ff [LANES];
   logic [CNT_W-1:0]        rem_ff [LANES];
   logic [DIV_W-1:0]        quo_in [LANES];
   logic [CNT_W-1:0]        rem_in [LANES];
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic signed [TT_W-1:0]  job_temp;
   logic [HT_W-1:0]         job_humid;
   logic [CT_W-1:0]         job_co2;
   logic [CNT_W-1:0]        job_count;
   logic [DIV_W-1:0]        temp_mag;
   logic [DIV_W-1:0]        temp_quo;
   logic [OUT_W+CNT_W-1:0]  count_ext;
   logic                    take;
   logic                    load_out;

   // Job fields
   assign job_temp  = pop_data[CNT_W+CT_W+HT_W +: TT_W];
   assign job_humid = pop_data[CNT_W+CT_W +: HT_W];
   assign job_co2   = pop_data[CNT_W +: CT_W];
   assign job_count = pop_data[CNT_W-1:0];
   assign temp_mag  = job_temp[TT_W-1] ? DIV_W'(-job_temp) : DIV_W'(job_temp);

   assign pop       = (state_ff == B_IDLE) && !queue_status.empty;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign load_out  = (state_ff == B_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   // Result stays valid until transferred; a new one loads only when it is empty or being taken
   assign rsp_valid_in = load_out || (rsp_valid_ff && !take);

   // One restoring step per lane: shift in a dividend bit, subtract if it fits
   always_comb begin
      logic [CNT_W:0] shifted;
      logic [CNT_W:0] diff;
      logic           fits;
      for (int i = 0; i < LANES; i++) begin
         shifted   = {rem_ff[i], quo_ff[i][DIV_W-1]};
         diff      = shifted - {1'b0, divisor_ff};
         fits      = (shifted >= {1'b0, divisor_ff});
         rem_in[i] = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in[i] = {quo_ff[i][DIV_W-2:0], fits};
      end
   end

   // Quotient sign restore and count sized to the port
   assign temp_quo  = neg_ff ? -quo_ff[LANE_T] : quo_ff[LANE_T];
   assign count_ext = {{OUT_W{1'b0}}, divisor_ff};

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  divisor_ff     <= job_count;
                  neg_ff         <= job_temp[TT_W-1];
                  quo_ff[LANE_T] <= temp_mag;
                  quo_ff[LANE_H] <= {{(DIV_W-HT_W){1'b0}}, job_humid};
                  quo_ff[LANE_C] <= {{(DIV_W-CT_W){1'b0}}, job_co2};
                  for (int i = 0; i < LANES; i++) begin
                     rem_ff[i] <= '0;
                  end
                  step_ff  <= '0;
                  state_ff <= B_RUN;
               end
            end
            B_RUN: begin
               for (int i = 0; i < LANES; i++) begin
                  quo_ff[i] <= quo_in[i];
                  rem_ff[i] <= rem_in[i];
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(DIV_W - 1)) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (load_out) begin
                  rsp_avg_temp_centi  <= temp_quo[cwa_pkg::TEMP_W-1:0];
                  rsp_avg_humid_centi <= quo_ff[LANE_H][cwa_pkg::HUMID_W-1:0];
                  rsp_avg_co2_ppm     <= quo_ff[LANE_C][cwa_pkg::CO2_W-1:0];
                  rsp_valid_entries   <= count_ext[OUT_W-1:0];
                  state_ff            <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // Every queued job covers at least one reading
   assert property (@(posedge clock) disable iff (reset) pop |-> (job_count != '0))
      else $error("job with zero entries reached the divider");

   // Temperature lane's partial remainder stays below the divisor while running
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == B_RUN) |-> (rem_ff[LANE_T] < divisor_ff))
      else $error("divider remainder not below divisor");

   // A finished division never overwrites a result not yet transferred
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_avg_co2_ppm)))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* hdl/three_channel_window_average.sv */
// Top level: sliding-window mean of temperature, humidity and CO2 readings.
//
// Usage:
//   req_* carries one reading per transfer (req_valid high, req_stall low at a
//   clock edge). Each reading enters a ring of DEPTH entries; the block returns
//   one rsp_* transfer per reading with the truncated mean of each channel over
//   the readings held so far and their count in rsp_valid_entries.
//   Result valid rises once the job of a transferred request has passed the front
//   end, the job queue and the divider. The three-lane divider, which retires one
//   quotient bit per cycle and takes a new job only once its last result is
//   loaded, sets the sustained rate. The front end takes one reading at a time
//   and a two-job queue lets it run ahead.
//   rsp_stall holds the result register; the divider then waits with its next
//   result, the queue fills and req_stall rises.
//   Reset (synchronous, active high) empties the window, totals and queue; the
//   sample ring needs no clearing since entries are read only after written.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_window_average #(
   parameter int DEPTH = cwa_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [cwa_pkg::TEMP_W-1:0]       req_temp_centi,
   input  wire logic        [cwa_pkg::HUMID_W-1:0]      req_humid_centi,
   input  wire logic        [cwa_pkg::CO2_W-1:0]        req_co2_ppm,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [cwa_pkg::TEMP_W-1:0]            rsp_avg_temp_centi,
   output logic        [cwa_pkg::HUMID_W-1:0]           rsp_avg_humid_centi,
   output logic        [cwa_pkg::CO2_W-1:0]             rsp_avg_co2_ppm,
   output logic        [cwa_pkg::COUNT_OUT_W-1:0]       rsp_valid_entries
);

   localparam int JOB_W = cwa_pkg::job_width(DEPTH);

   cwa_pkg::queue_status_type   queue_status;
   logic                        push;
   logic [JOB_W-1:0]            push_data;
   logic                        pop;
   logic [JOB_W-1:0]            pop_data;

   // Ring update and running totals
   cwa_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temp_centi  (req_temp_centi),
      .req_humid_centi (req_humid_centi),
      .req_co2_ppm     (req_co2_ppm),
      .queue_status    (queue_status),
      .push            (push),
      .push_data       (push_data)
   );

   // Jobs waiting for the divider
   cwa_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (queue_status),
      .pop_data  (pop_data)
   );

   // Division and result register
   cwa_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_status        (queue_status),
      .pop_data            (pop_data),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_avg_temp_centi  (rsp_avg_temp_centi),
      .rsp_avg_humid_centi (rsp_avg_humid_centi),
      .rsp_avg_co2_ppm     (rsp_avg_co2_ppm),
      .rsp_valid_entries   (rsp_valid_entries)
   );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the three-channel sliding-window average block.
`timescale 1ns / 1ps

module tb_top;

   localparam int TEMP_W           = cwa_pkg::TEMP_W;
   localparam int HUMID_W          = cwa_pkg::HUMID_W;
   localparam int CO2_W            = cwa_pkg::CO2_W;
   localparam int COUNT_OUT_W      = cwa_pkg::COUNT_OUT_W;
   localparam int WINDOW           = cwa_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_READINGS  = 1730;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_AT     = 500;      // results taken before the long receiver stall
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TIMEOUT_NS       = 2_000_000;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp;
      logic        [HUMID_W-1:0] humid;
      logic        [CO2_W-1:0]   co2;
   } reading_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0]      avg_temp;
      logic        [HUMID_W-1:0]     avg_humid;
      logic        [CO2_W-1:0]       avg_co2;
      logic        [COUNT_OUT_W-1:0] entries;
   } window_mean_type;

   typedef struct {
      reading_type     rd;
      bit              typed;
      window_mean_type mean;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid       = 1'b0;
   logic                       req_stall;
   logic signed [TEMP_W-1:0]   req_temp_centi  = '0;
   logic        [HUMID_W-1:0]  req_humid_centi = '0;
   logic        [CO2_W-1:0]    req_co2_ppm     = '0;
   logic                       rsp_valid;
   logic                       rsp_stall       = 1'b0;
   logic signed [TEMP_W-1:0]   rsp_avg_temp_centi;
   logic        [HUMID_W-1:0]  rsp_avg_humid_centi;
   logic        [CO2_W-1:0]    rsp_avg_co2_ppm;
   logic [COUNT_OUT_W-1:0]     rsp_valid_entries;

   // Window predictor state
   int ring_temp  [WINDOW];
   int ring_humid [WINDOW];
   int ring_co2   [WINDOW];
   int window_pos   = 0;
   int window_fill  = 0;
   int sum_temp     = 0;
   int sum_humid    = 0;
   int sum_co2      = 0;
   int window_wraps = 0;

   window_mean_type expected_means[$];
   stim_row_type    directed_rows[$];

   int          error_count        = 0;
   int          readings_sent      = 0;
   int          averages_taken     = 0;
   int          input_stall_cycles = 0;
   int          raw_bit_readings   = 0;
   int          run_left           = 0;
   reading_type run_reading;
   bit          long_hold_done     = 1'b0;

   three_channel_window_average u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_temp_centi      (req_temp_centi),
      .req_humid_centi     (req_humid_centi),
      .req_co2_ppm         (req_co2_ppm),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_avg_temp_centi  (rsp_avg_temp_centi),
      .rsp_avg_humid_centi (rsp_avg_humid_centi),
      .rsp_avg_co2_ppm     (rsp_avg_co2_ppm),
      .rsp_valid_entries   (rsp_valid_entries)
   );

   // Clock and reset
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin : reset_seq
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Insert one reading into the window and return the truncated means
   function automatic window_mean_type advance_window(input reading_type rd);
      window_mean_type m;
      int              tv;
      tv = int'($signed(rd.temp));
      if (window_fill == WINDOW) begin
         // full: drop the reading about to be overwritten
         sum_temp  -= ring_temp[window_pos];
         sum_humid -= ring_humid[window_pos];
         sum_co2   -= ring_co2[window_pos];
      end else begin
         window_fill++;
      end
      ring_temp[window_pos]  = tv;
      ring_humid[window_pos] = int'(rd.humid);
      ring_co2[window_pos]   = int'(rd.co2);
      sum_temp  += tv;
      sum_humid += int'(rd.humid);
      sum_co2   += int'(rd.co2);
      if (window_pos == WINDOW - 1) begin
         window_pos = 0;
         window_wraps++;
      end else begin
         window_pos++;
      end
      // int division truncates toward zero
      m.avg_temp  = TEMP_W'(sum_temp / window_fill);
      m.avg_humid = HUMID_W'(sum_humid / window_fill);
      m.avg_co2   = CO2_W'(sum_co2 / window_fill);
      m.entries   = COUNT_OUT_W'(window_fill);
      return m;
   endfunction

   function automatic void add_row(input int t, input int h, input int c, input bit typed,
                                   input int et, input int eh, input int ec, input int en);
      stim_row_type r;
      r.rd.temp        = t[TEMP_W-1:0];
      r.rd.humid       = h[HUMID_W-1:0];
      r.rd.co2         = c[CO2_W-1:0];
      r.typed          = typed;
      r.mean.avg_temp  = et[TEMP_W-1:0];
      r.mean.avg_humid = eh[HUMID_W-1:0];
      r.mean.avg_co2   = ec[CO2_W-1:0];
      r.mean.entries   = en[COUNT_OUT_W-1:0];
      directed_rows.push_back(r);
   endfunction

   // Random reading: mostly in range, some raw bit patterns, some edge values
   // and now and then a run of one edge reading long enough to fill the window
   function automatic reading_type draw_reading();
      reading_type rd;
      int          pick;
      int          t;
      if (run_left > 0) begin
         run_left--;
         return run_reading;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         rd.temp  = TEMP_W'($urandom);
         rd.humid = HUMID_W'($urandom);
         rd.co2   = CO2_W'($urandom);
         raw_bit_readings++;
      end else if (pick < 22) begin
         case ($urandom_range(0, 3))
            0: t = -16384;
            1: t = 16383;
            2: t = -4000;
            default: t = 12500;
         endcase
         rd.temp  = t[TEMP_W-1:0];
         rd.humid = ($urandom_range(0, 2) == 0) ? HUMID_W'(0) :
                    ($urandom_range(0, 1) == 0) ? HUMID_W'(10000) : HUMID_W'(16383);
         rd.co2   = ($urandom_range(0, 2) == 0) ? CO2_W'(0) :
                    ($urandom_range(0, 1) == 0) ? CO2_W'(10000) : CO2_W'(16383);
         if ($urandom_range(0, 9) == 0) begin
            run_reading = rd;
            run_left    = $urandom_range(16, 24);
         end
      end else begin
         t        = int'($urandom_range(0, 16500)) - 4000;
         rd.temp  = t[TEMP_W-1:0];
         rd.humid = HUMID_W'($urandom_range(0, 10000));
         rd.co2   = CO2_W'($urandom_range(0, 10000));
      end
      return rd;
   endfunction

   // Offer one reading after a random gap; predict once it is transferred
   task automatic offer_reading(input reading_type rd, input bit typed,
                                input window_mean_type typed_mean, input bit no_gap);
      int              gap;
      window_mean_type predicted;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_temp_centi  <= rd.temp;
      req_humid_centi <= rd.humid;
      req_co2_ppm     <= rd.co2;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = advance_window(rd);
      expected_means.push_back(typed ? typed_mean : predicted);
      readings_sent++;
      @(negedge clock);
   endtask

   // Sender: directed table, then random readings, then drain and verdict
   initial begin : drive_readings
      int i;
      add_row(-4000, 0, 0, 1'b1, -4000, 0, 0, 1);
      add_row(12500, 10000, 10000, 1'b0, 0, 0, 0, 0);
      add_row(-16384, 16383, 16383, 1'b0, 0, 0, 0, 0);
      add_row(16383, 0, 16383, 1'b0, 0, 0, 0, 0);
      // sixteen minimum-temperature, full-scale readings: window holds only these
      for (i = 0; i < WINDOW - 1; i++) add_row(-16384, 16383, 16383, 1'b0, 0, 0, 0, 0);
      add_row(-16384, 16383, 16383, 1'b1, -16384, 16383, 16383, WINDOW);
      add_row(16383, 0, 0, 1'b0, 0, 0, 0, 0);
      add_row(0, 0, 0, 1'b0, 0, 0, 0, 0);
      add_row(-1, 1, 1, 1'b0, 0, 0, 0, 0);
      add_row(12500, 10000, 10000, 1'b0, 0, 0, 0, 0);

      while (reset) @(negedge clock);
      foreach (directed_rows[k])
         offer_reading(directed_rows[k].rd, directed_rows[k].typed, directed_rows[k].mean, 1'b0);
      // every third block of readings goes back to back
      for (i = 0; i < RANDOM_READINGS; i++)
         offer_reading(draw_reading(), 1'b0, '0, ((i / 150) % 3) == 2);
      req_valid <= 1'b0;

      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d readings (%0d directed, %0d raw bit patterns), %0d averages checked",
               readings_sent, directed_rows.size(), raw_bit_readings, averages_taken);
      $display("Summary: window wrapped %0d times, input held off for %0d cycles",
               window_wraps, input_stall_cycles);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Receiver: random hold-off per result, none in every third block of results, one long stall
   initial begin : accept_averages
      int hold;
      while (reset) @(negedge clock);
      forever begin
         if (averages_taken == LONG_HOLD_AT && !long_hold_done) begin
            hold           = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (((averages_taken / 200) % 3) == 1) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compare each result transfer with the oldest expected mean
   always @(posedge clock) begin : check_averages
      window_mean_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         averages_taken++;
         if (expected_means.size() == 0) begin
            $error("unexpected result transfer: avg_temp_centi %0d, valid_entries %0d",
                   rsp_avg_temp_centi, rsp_valid_entries);
            error_count++;
         end else begin
            want = expected_means.pop_front();
            if (rsp_avg_temp_centi !== want.avg_temp) begin
               $error("avg_temp_centi: expected %0d, got %0d", want.avg_temp, rsp_avg_temp_centi);
               error_count++;
            end
            if (rsp_avg_humid_centi !== want.avg_humid) begin
               $error("avg_humid_centi: expected %0d, got %0d",
                      want.avg_humid, rsp_avg_humid_centi);
               error_count++;
            end
            if (rsp_avg_co2_ppm !== want.avg_co2) begin
               $error("avg_co2_ppm: expected %0d, got %0d", want.avg_co2, rsp_avg_co2_ppm);
               error_count++;
            end
            if (rsp_valid_entries !== want.entries) begin
               $error("valid_entries: expected %0d, got %0d", want.entries, rsp_valid_entries);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && req_stall === 1'b1) input_stall_cycles++;
   end

   // Hard stop if the run hangs
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
